[sv/i2cms_pkg.sv]
// Shared types, opcodes and step tables for the I2C master bit sequencer.
package i2cms_pkg;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned STEP_W  = 5;
    localparam int unsigned STEPS   = 1 << STEP_W;
    localparam logic [7:0]  MSB_MASK = 8'h80;
    localparam logic [TICK_W-1:0] STEP_TICKS_RESET = 16'd1000;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_SACK  = 3'd4,
        OP_RACK  = 3'd5
    } op_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_in;
    } in_word_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       cmd_ready;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } out_word_t;

    // Pin and data state that a single step may change.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       ack;
        logic [7:0] shift;
    } pin_state_t;

    // Command setup handed to the step decoder.
    typedef struct packed {
        logic              run;
        logic [2:0]        op;
        logic [STEP_W-1:0] idx;
        logic              sack;
        logic              sda_in;
    } step_ctrl_t;

    typedef logic [STEPS-1:0][2:0] div3_tab_t;
    typedef logic [STEPS-1:0][1:0] mod3_tab_t;

    // Step index split into bit number and phase within a three-step bit.
    function automatic div3_tab_t build_div3();
        div3_tab_t t;
        for (int i = 0; i < STEPS; i++) begin
            t[i] = 3'((i / 3) & 7);
        end
        return t;
    endfunction

    function automatic mod3_tab_t build_mod3();
        mod3_tab_t t;
        for (int i = 0; i < STEPS; i++) begin
            t[i] = 2'(i % 3);
        end
        return t;
    endfunction

    localparam div3_tab_t DIV3 = build_div3();
    localparam mod3_tab_t MOD3 = build_mod3();

    // Number of pin steps in each command; unused codes have none.
    function automatic logic [STEP_W-1:0] op_len(input logic [2:0] op);
        logic [STEP_W-1:0] n;
        case (op_t'(op))
            OP_START: n = 5'd4;
            OP_STOP:  n = 5'd3;
            OP_WRITE: n = 5'd24;
            OP_READ:  n = 5'd25;
            OP_SACK:  n = 5'd3;
            OP_RACK:  n = 5'd4;
            default:  n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

[sv/i2cms_step.sv]
// Pin step decoder: applies one step of the current command to the pin state.
module i2cms_step (
    input  i2cms_pkg::step_ctrl_t ctrl,
    input  i2cms_pkg::pin_state_t cur,
    output i2cms_pkg::pin_state_t nxt
);
    import i2cms_pkg::*;

    logic [STEP_W-1:0] ridx;
    logic [2:0]        wbit;
    logic [1:0]        wphase;
    logic [2:0]        rbit;
    logic [1:0]        rphase;

    assign ridx   = ctrl.idx - STEP_W'(1);
    assign wbit   = DIV3[ctrl.idx];
    assign wphase = MOD3[ctrl.idx];
    assign rbit   = DIV3[ridx];
    assign rphase = MOD3[ridx];

    always_comb begin
        nxt = cur;
        if (ctrl.run) begin
            case (op_t'(ctrl.op))
                OP_START: begin
                    case (ctrl.idx)
                        5'd0:    nxt.sda = 1'b1;
                        5'd1:    nxt.scl = 1'b1;
                        5'd2:    nxt.sda = 1'b0;
                        default: nxt.scl = 1'b0;
                    endcase
                end
                OP_STOP: begin
                    case (ctrl.idx)
                        5'd0:    nxt.sda = 1'b0;
                        5'd1:    nxt.scl = 1'b1;
                        default: nxt.sda = 1'b1;
                    endcase
                end
                OP_WRITE: begin
                    case (wphase)
                        2'd0:    nxt.sda = cur.shift[3'd7 - wbit];
                        2'd1:    nxt.scl = 1'b1;
                        default: nxt.scl = 1'b0;
                    endcase
                end
                OP_READ: begin
                    if (ctrl.idx == '0) begin
                        nxt.sda = 1'b1;
                    end else begin
                        case (rphase)
                            2'd0: nxt.scl = 1'b1;
                            2'd1: begin
                                if (ctrl.sda_in) begin
                                    nxt.shift = cur.shift | (MSB_MASK >> rbit);
                                end
                            end
                            default: nxt.scl = 1'b0;
                        endcase
                    end
                end
                OP_SACK: begin
                    case (ctrl.idx)
                        5'd0:    nxt.sda = ctrl.sack;
                        5'd1:    nxt.scl = 1'b1;
                        default: nxt.scl = 1'b0;
                    endcase
                end
                OP_RACK: begin
                    case (ctrl.idx)
                        5'd0:    nxt.sda = 1'b1;
                        5'd1:    nxt.scl = 1'b1;
                        5'd2:    nxt.ack = ctrl.sda_in;
                        default: nxt.scl = 1'b0;
                    endcase
                end
                default: nxt = cur;
            endcase
        end
    end

endmodule

[sv/i2c_master_bit_sequencer_unit.sv]
// Top level of the I2C master bit sequencer: input register, tick logic, result register.
//
//  channel | ports                          | word
//  --------+--------------------------------+------------------------------
//  input   | s_valid, s_ready, s_data       | one tick: command and SDA in
//  result  | m_valid, m_ready, m_data       | pin drive and status per tick
//  config  | cfg_valid, cfg_ready, cfg_data | step_ticks, 16 bits
//
// Every input word yields exactly one result word, which moves from the input register
// into the result register (m_data) when the result side is not stalled; one word is
// taken per cycle unless m_ready stalls, set by the update loop on the sequencer state
// registers. Reset (aresetn low, synchronous) releases both lines and empties both
// stages. A stall on m_ready holds the result register and then the input register;
// s_ready drops only when both are full. Config writes are always taken.
module i2c_master_bit_sequencer_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  i2cms_pkg::in_word_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output i2cms_pkg::out_word_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);
    import i2cms_pkg::*;

    // Input stage.
    logic     in_vld_reg, in_vld_next;
    in_word_t in_reg;

    // Result stage.
    logic      out_vld_reg, out_vld_next;
    out_word_t out_reg, out_next;

    // Sequencer state.
    logic [TICK_W-1:0] step_ticks_reg;
    logic              busy_reg, busy_next;
    logic [2:0]        op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    pin_state_t        pin_reg, pin_next;
    logic              sack_reg, sack_next;
    logic [7:0]        rx_reg, rx_next;

    logic              advance;
    logic [TICK_W-1:0] tick_inc;
    logic [STEP_W-1:0] step_inc;
    logic              step_end;
    logic              last_step;
    logic              start_cmd;
    logic              done;
    step_ctrl_t        ctrl;
    pin_state_t        pin_cur;
    pin_state_t        pin_step;

    // The input word moves on whenever the result register can take its result.
    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    assign in_vld_next  = s_ready ? s_valid : in_vld_reg;
    assign out_vld_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_vld_reg);

    // Tick counting of the step being held; a count that wraps also ends it.
    assign tick_inc  = tick_reg + TICK_W'(1);
    assign step_end  = (tick_inc >= step_ticks_reg) || (tick_inc == '0);
    assign step_inc  = step_reg + STEP_W'(1);
    assign last_step = step_inc >= op_len(op_reg);
    assign start_cmd = !busy_reg && in_reg.cmd_valid && (in_reg.op <= 3'(OP_RACK));
    assign done      = busy_reg && step_end && last_step;

    // Set up the step to run: the next step while busy, or step zero of a new
    // command, with the byte and ack level that the command loads.
    always_comb begin
        pin_cur = pin_reg;
        ctrl.sda_in = in_reg.sda_in;
        if (busy_reg) begin
            ctrl.run  = step_end && !last_step;
            ctrl.op   = op_reg;
            ctrl.idx  = step_inc;
            ctrl.sack = sack_reg;
        end else begin
            ctrl.run  = start_cmd;
            ctrl.op   = in_reg.op;
            ctrl.idx  = '0;
            ctrl.sack = (in_reg.op == 3'(OP_SACK)) ? in_reg.ack_to_send : sack_reg;
            if (start_cmd && in_reg.op == 3'(OP_WRITE)) begin
                pin_cur.shift = in_reg.tx_byte;
            end else if (start_cmd && in_reg.op == 3'(OP_READ)) begin
                pin_cur.shift = '0;
            end
        end
    end

    i2cms_step u_step (
        .ctrl (ctrl),
        .cur  (pin_cur),
        .nxt  (pin_step)
    );

    always_comb begin
        busy_next = busy_reg;
        op_next   = op_reg;
        step_next = step_reg;
        tick_next = tick_reg;
        pin_next  = pin_reg;
        sack_next = sack_reg;
        rx_next   = rx_reg;
        out_next  = out_reg;
        if (advance) begin
            pin_next = pin_step;
            if (busy_reg) begin
                if (step_end) begin
                    tick_next = '0;
                    step_next = step_inc;
                    if (last_step) begin
                        busy_next = 1'b0;
                        if (op_reg == 3'(OP_READ)) begin
                            rx_next = pin_reg.shift;
                        end
                    end
                end else begin
                    tick_next = tick_inc;
                end
            end else if (start_cmd) begin
                busy_next = 1'b1;
                op_next   = in_reg.op;
                step_next = '0;
                tick_next = '0;
                sack_next = ctrl.sack;
            end
            out_next.scl_out   = pin_step.scl;
            out_next.sda_out   = pin_step.sda;
            out_next.cmd_ready = !busy_next;
            out_next.done_res  = done;
            out_next.rx_byte   = rx_next;
            out_next.ack_seen  = pin_step.ack;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            step_ticks_reg <= STEP_TICKS_RESET;
            busy_reg       <= 1'b0;
            op_reg         <= '0;
            step_reg       <= '0;
            tick_reg       <= '0;
            pin_reg        <= '{scl: 1'b1, sda: 1'b1, ack: 1'b0, shift: 8'h00};
            sack_reg       <= 1'b0;
            rx_reg         <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid && cfg_ready) begin
                step_ticks_reg <= cfg_data;
            end
            busy_reg <= busy_next;
            op_reg   <= op_next;
            step_reg <= step_next;
            tick_reg <= tick_next;
            pin_reg  <= pin_next;
            sack_reg <= sack_next;
            rx_reg   <= rx_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_reg <= s_data;
        end
        out_reg <= out_next;
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule

[sv/i2cms_checker.sv]
// Port-level checker for the I2C master bit sequencer, bound to the top level.
module i2cms_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input i2cms_pkg::out_word_t m_data
);
    import i2cms_pkg::*;

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed under stall");

    // The done tick always leaves the sequencer idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> m_data.cmd_ready)
        else $error("done without ready");

    // Reset empties the result stage.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // With the result stage free, the input side is never blocked.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result stage");

endmodule

bind i2c_master_bit_sequencer_unit i2cms_checker u_i2cms_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[verif/tb.sv]
// Self-checking testbench for the I2C master bit sequencer: directed table, then random ticks.
`timescale 1ns / 1ps

module tb;
    import i2cms_pkg::*;

    // Op codes that the sequencer must ignore.
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    // Number of pin steps per command, indexed by op code.
    localparam logic [4:0] STEP_COUNT [6] = '{5'd4, 5'd3, 5'd24, 5'd25, 5'd3, 5'd4};

    // Result words that can be read straight off the spec.
    localparam out_word_t LINES_IDLE  = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
    localparam out_word_t START_TAKEN = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};

    localparam int PLAN_ROWS = 21;
    localparam int RANDOM_PHASES = 4;
    localparam int TICKS_PER_PHASE = 222;
    localparam int unsigned HOLD_OFF_CYCLES = 60;

    // One row of the directed table. The row's word is offered first, then pad_len
    // plain ticks with no command; a row may first write step_ticks once drained.
    typedef struct packed {
        logic        do_cfg;
        logic [15:0] cfg_val;
        in_word_t    word;
        logic [7:0]  pad_len;
        logic        pad_rand;
        logic        typed;
        out_word_t   want;
    } plan_row_t;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_word_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_word_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [15:0] cfg_data = '0;

    i2c_master_bit_sequencer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sequencer predictor. This is a private copy of the pin sequencer state,
    // starting at its reset values, advanced once for every accepted input word.
    // ------------------------------------------------------------------
    logic [15:0] cfg_ticks = STEP_TICKS_RESET;
    logic        scl_lv    = 1'b1;
    logic        sda_lv    = 1'b1;
    logic        seq_busy  = 1'b0;
    op_t         cur_op    = OP_START;
    logic [4:0]  step_no   = '0;
    logic [15:0] tick_cnt  = '0;
    logic [7:0]  shreg     = '0;
    logic        ack_lv    = 1'b0;
    logic        sack_lv   = 1'b0;
    logic [7:0]  rx_lv     = '0;

    // Result words still owed by the block, oldest first.
    out_word_t pin_words_due [$];
    int unsigned mismatches = 0;

    // Sender idle and receiver stall rates, in percent of cycles.
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;

    // The driver bumps hold_requests to ask the receiver for one long hold-off.
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;

    // Carries out the action of the current step. Writes and reads spend three
    // steps per bit (data or SCL high, sample or hold, SCL low), MSB first; a read
    // has one extra leading step that releases SDA.
    function automatic void apply_step(input logic sda_i);
        logic [4:0] k;
        logic [2:0] bitn;
        logic [1:0] ph;
        k = (cur_op == OP_READ) ? step_no - 5'd1 : step_no;
        bitn = 3'(k / 5'd3);
        ph = 2'(k % 5'd3);
        case (cur_op)
            OP_START: begin
                if (step_no == 5'd0) sda_lv = 1'b1;
                else if (step_no == 5'd1) scl_lv = 1'b1;
                else if (step_no == 5'd2) sda_lv = 1'b0;
                else scl_lv = 1'b0;
            end
            OP_STOP: begin
                if (step_no == 5'd0) sda_lv = 1'b0;
                else if (step_no == 5'd1) scl_lv = 1'b1;
                else sda_lv = 1'b1;
            end
            OP_WRITE: begin
                if (ph == 2'd0) sda_lv = shreg[3'd7 - bitn];
                else if (ph == 2'd1) scl_lv = 1'b1;
                else scl_lv = 1'b0;
            end
            OP_READ: begin
                if (step_no == 5'd0) sda_lv = 1'b1;
                else if (ph == 2'd0) scl_lv = 1'b1;
                else if (ph == 2'd1) begin
                    if (sda_i) shreg[3'd7 - bitn] = 1'b1;
                end else scl_lv = 1'b0;
            end
            OP_SACK: begin
                if (step_no == 5'd0) sda_lv = sack_lv;
                else if (step_no == 5'd1) scl_lv = 1'b1;
                else scl_lv = 1'b0;
            end
            OP_RACK: begin
                if (step_no == 5'd0) sda_lv = 1'b1;
                else if (step_no == 5'd1) scl_lv = 1'b1;
                else if (step_no == 5'd2) ack_lv = sda_i;
                else scl_lv = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // Advances the sequencer by one tick and returns the pin and status word that
    // the block must produce for it. A zero step_ticks behaves like one because every
    // tick count is at or above zero and so ends the step.
    function automatic out_word_t tick_sequencer(input in_word_t w);
        out_word_t r;
        logic done;
        done = 1'b0;
        if (seq_busy) begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= cfg_ticks || tick_cnt == 16'd0) begin
                tick_cnt = '0;
                step_no = step_no + 5'd1;
                if (step_no >= STEP_COUNT[cur_op]) begin
                    seq_busy = 1'b0;
                    done = 1'b1;
                    if (cur_op == OP_READ) rx_lv = shreg;
                end else begin
                    apply_step(w.sda_in);
                end
            end
        end else if (w.cmd_valid && w.op <= OP_RACK) begin
            seq_busy = 1'b1;
            cur_op = op_t'(w.op);
            step_no = '0;
            tick_cnt = '0;
            if (w.op == OP_WRITE) shreg = w.tx_byte;
            else if (w.op == OP_READ) shreg = '0;
            if (w.op == OP_SACK) sack_lv = w.ack_to_send;
            apply_step(w.sda_in);
        end
        r.scl_out   = scl_lv;
        r.sda_out   = sda_lv;
        r.cmd_ready = !seq_busy;
        r.done_res  = done;
        r.rx_byte   = rx_lv;
        r.ack_seen  = ack_lv;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic plan_row_t mk(input logic do_cfg, input logic [15:0] cfg_val,
                                     input logic cv, input logic [2:0] op,
                                     input logic [7:0] tx, input logic ack,
                                     input logic sda, input logic [7:0] pad_len,
                                     input logic pad_rand, input logic typed,
                                     input out_word_t want);
        plan_row_t r;
        r.do_cfg   = do_cfg;
        r.cfg_val  = cfg_val;
        r.word     = '{cv, op, tx, ack, sda};
        r.pad_len  = pad_len;
        r.pad_rand = pad_rand;
        r.typed    = typed;
        r.want     = want;
        return r;
    endfunction

    // Random tick. Most ticks that find the sequencer idle carry a command, so
    // commands run back to back; a few commands land while busy, and a few use
    // the spare op codes, which must both be ignored.
    function automatic in_word_t pick_tick_word();
        in_word_t w;
        int unsigned roll;
        roll = $urandom_range(99);
        w.cmd_valid   = seq_busy ? (roll < 8) : (roll < 75);
        w.op          = ($urandom_range(99) < 5) ? 3'($urandom_range(7, 6))
                                                 : 3'($urandom_range(5, 0));
        w.tx_byte     = 8'($urandom);
        w.ack_to_send = 1'($urandom);
        w.sda_in      = 1'($urandom);
        return w;
    endfunction

    // Offers one word on the input channel, after an optional random gap, and
    // returns at the edge that accepts it. The word stays on the bus until then.
    // The predictor advances at acceptance, so the next word is picked knowing
    // the sequencer state. Typed rows queue their hand-written result instead.
    task automatic offer_tick(input in_word_t w, input logic typed, input out_word_t want);
        out_word_t pred;
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        pred = tick_sequencer(w);
        pin_words_due.push_back(typed ? want : pred);
    endtask

    // Writes step_ticks while both stages are empty: the input is held off until every
    // owed result has come back, and only then is the write made.
    task automatic write_step_ticks(input logic [15:0] v);
        s_valid <= 1'b0;
        while (pin_words_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_ticks = v;
    endtask

    // ------------------------------------------------------------------
    // Result receiver. Normally m_ready follows the stall rate of the current
    // phase. On request it holds off for a long fixed stretch while the sender
    // keeps offering words, which fills both stages and must drop s_ready.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_OFF_CYCLES;
            m_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker. Every accepted result word is matched field by field
    // against the oldest owed word; a word with nothing owed is a failure too.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        out_word_t owed;
        if (aresetn && m_valid && m_ready) begin
            if (pin_words_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, m_data);
            end else begin
                owed = pin_words_due.pop_front();
                check_field("scl_out",   8'(owed.scl_out),   8'(m_data.scl_out));
                check_field("sda_out",   8'(owed.sda_out),   8'(m_data.sda_out));
                check_field("cmd_ready", 8'(owed.cmd_ready), 8'(m_data.cmd_ready));
                check_field("done_res",  8'(owed.done_res),  8'(m_data.done_res));
                check_field("rx_byte",   owed.rx_byte,       m_data.rx_byte);
                check_field("ack_seen",  8'(owed.ack_seen),  8'(m_data.ack_seen));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random phases, drain, verdict.
    // ------------------------------------------------------------------
    initial begin
        plan_row_t plan [PLAN_ROWS];
        plan_row_t r;
        in_word_t pad_w;
        logic [15:0] phase_ticks;

        // The directed table. Pad lengths are chosen so that each command runs
        // to its done tick before the next row, except where a row is meant to
        // hit a busy sequencer or the done tick itself.
        plan = '{
            // Idle tick right after reset: both lines released, nothing read yet.
            mk(1'b0, 16'd0, 1'b0, OP_START, 8'h00, 1'b0, 1'b1, 8'd0, 1'b0, 1'b1, LINES_IDLE),
            // Spare op codes with a command flag are ignored.
            mk(1'b0, 16'd0, 1'b1, OP_SPARE7, 8'hFF, 1'b1, 1'b1, 8'd0, 1'b0, 1'b1, LINES_IDLE),
            mk(1'b0, 16'd0, 1'b1, OP_SPARE6, 8'h00, 1'b0, 1'b0, 8'd0, 1'b0, 1'b1, LINES_IDLE),
            // Start under the reset step_ticks of 1000; the first step acts at once.
            mk(1'b0, 16'd0, 1'b1, OP_START, 8'h00, 1'b0, 1'b1, 8'd3, 1'b0, 1'b1, START_TAKEN),
            // Shortening step_ticks mid-step ends the long step on the next tick.
            mk(1'b1, 16'd1, 1'b0, OP_START, 8'h00, 1'b0, 1'b1, 8'd6, 1'b0, 1'b0, '0),
            // A step_ticks of zero acts like one; a read during the write is ignored.
            mk(1'b1, 16'd0, 1'b1, OP_WRITE, 8'hFF, 1'b0, 1'b1, 8'd2, 1'b0, 1'b0, '0),
            mk(1'b0, 16'd0, 1'b1, OP_READ, 8'h00, 1'b0, 1'b0, 8'd22, 1'b0, 1'b0, '0),
            mk(1'b1, 16'd2, 1'b1, OP_WRITE, 8'h00, 1'b1, 1'b0, 8'd50, 1'b0, 1'b0, '0),
            mk(1'b1, 16'd1, 1'b1, OP_WRITE, 8'hA5, 1'b0, 1'b1, 8'd23, 1'b0, 1'b0, '0),
            // A command on the done tick is ignored; the next one is taken.
            mk(1'b0, 16'd0, 1'b1, OP_START, 8'h00, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0, '0),
            mk(1'b0, 16'd0, 1'b1, OP_START, 8'h00, 1'b0, 1'b1, 8'd4, 1'b0, 1'b0, '0),
            // Reads with SDA high, low and random throughout.
            mk(1'b0, 16'd0, 1'b1, OP_READ, 8'h00, 1'b0, 1'b1, 8'd25, 1'b0, 1'b0, '0),
            mk(1'b0, 16'd0, 1'b1, OP_READ, 8'hFF, 1'b1, 1'b0, 8'd25, 1'b0, 1'b0, '0),
            mk(1'b0, 16'd0, 1'b1, OP_READ, 8'h5A, 1'b0, 1'b1, 8'd25, 1'b1, 1'b0, '0),
            mk(1'b0, 16'd0, 1'b1, OP_SACK, 8'h00, 1'b0, 1'b1, 8'd3, 1'b0, 1'b0, '0),
            mk(1'b0, 16'd0, 1'b1, OP_SACK, 8'h00, 1'b1, 1'b0, 8'd3, 1'b0, 1'b0, '0),
            mk(1'b0, 16'd0, 1'b1, OP_RACK, 8'h00, 1'b0, 1'b0, 8'd4, 1'b0, 1'b0, '0),
            mk(1'b0, 16'd0, 1'b1, OP_RACK, 8'h00, 1'b1, 1'b1, 8'd4, 1'b0, 1'b0, '0),
            mk(1'b0, 16'd0, 1'b1, OP_STOP, 8'h00, 1'b0, 1'b1, 8'd3, 1'b0, 1'b0, '0),
            // Largest step_ticks: the start sits in its first step, then a short
            // setting cuts the step off.
            mk(1'b1, 16'hFFFF, 1'b1, OP_START, 8'h00, 1'b0, 1'b1, 8'd100, 1'b0, 1'b0, '0),
            mk(1'b1, 16'd3, 1'b0, OP_START, 8'h00, 1'b0, 1'b1, 8'd40, 1'b0, 1'b0, '0)
        };

        // Synchronous reset, held from time zero and never asserted again.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, with no idling on either side.
        for (int i = 0; i < PLAN_ROWS; i++) begin
            r = plan[i];
            if (r.do_cfg) write_step_ticks(r.cfg_val);
            offer_tick(r.word, r.typed, r.want);
            for (int k = 0; k < r.pad_len; k++) begin
                pad_w = '0;
                pad_w.sda_in = r.pad_rand ? 1'($urandom) : r.word.sda_in;
                offer_tick(pad_w, 1'b0, '0);
            end
        end

        // Random phases: no idling, sender gaps, receiver stalls, then both.
        // Each phase starts with a fresh step_ticks, kept short so commands finish.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin phase_ticks = 16'd1; gap_pct = 0;  stall_pct <= 0;  end
                1: begin phase_ticks = 16'd2; gap_pct = 83; stall_pct <= 0;  end
                2: begin phase_ticks = 16'($urandom_range(4, 1));
                         gap_pct = 0;  stall_pct <= 83; end
                default: begin phase_ticks = 16'd1; gap_pct = 30; stall_pct <= 30; end
            endcase
            write_step_ticks(phase_ticks);
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                // One long receiver hold-off while the sender keeps pushing words.
                if (p == 0 && n == 100) hold_requests <= hold_requests + 1;
                offer_tick(pick_tick_word(), 1'b0, '0);
            end
        end

        // Drain, then give any stray word time to show up.
        s_valid <= 1'b0;
        while (pin_words_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && pin_words_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
